// File: sv/tri2d_pkg.sv
// shared types and constants of the 2d three-anchor trilateration block
package tri2d_pkg;

    localparam int RNG_W  = 18;
    localparam int CRD_W  = 18;
    localparam int ID_W   = 8;
    localparam int OUT_W  = 20;
    localparam int QUO_W  = 22;
    localparam int NUM_W  = 61;
    localparam int DEN_W  = 40;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 24;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;
    localparam int OFFSET_X_MM = 185;
    localparam int OFFSET_Y_MM = -163;
    localparam int MIN_RANGES  = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_A_X    = 4'd0,
        REG_A_Y    = 4'd1,
        REG_B_X    = 4'd2,
        REG_B_Y    = 4'd3,
        REG_C_X    = 4'd4,
        REG_C_Y    = 4'd5,
        REG_IDS    = 4'd6,
        REG_LOADED = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [CRD_W-1:0] ax;
        logic signed [CRD_W-1:0] ay;
        logic signed [CRD_W-1:0] bx;
        logic signed [CRD_W-1:0] by;
        logic signed [CRD_W-1:0] cx;
        logic signed [CRD_W-1:0] cy;
        logic [3*ID_W-1:0]       ids;
        logic                    loaded;
    } t_cfg;

    typedef struct packed {
        logic vld;
        logic degen;
        logic neg_x;
        logic neg_y;
    } t_geom_ctl;

endpackage

// File: sv/trilateration_2d_three_anchor.sv
// top level of the 2d three-anchor trilateration block
//
// one ranging set enters on the s_axis channel per transfer and gives at most
// one result on the m_axis channel: the tag x and y position in mm with the
// fixed mounting offset added and saturated to 20 bits, plus a degenerate flag
// in m_axis_tuser (coordinates zero then). sets are dropped while the anchors
// are not loaded, with fewer than three ranges, or on an anchor id mismatch.
// anchor positions, ids and the loaded flag are written on the cfg channel,
// which is always ready; write it only while no set is in flight.
// from input transfer to output valid a set passes eight stages of products and
// operand setup, 23 stages of the two bit-per-stage dividers and the output
// register. throughput is one set per cycle while the output is not stalled.
// the whole pipeline advances whenever the output register is empty or taken,
// so a stalled receiver holds every stage and s_axis_tready falls with it;
// nothing is lost or repeated. reset clears all valid bits and the
// configuration registers.
module trilateration_2d_three_anchor
    import tri2d_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // range_a_mm, range_b_mm, range_c_mm, reported_id_a/b/c, range_count
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tag_x_mm, tag_y_mm
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic                   m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    t_cfg              r_cfg;
    logic              w_en;
    t_geom_ctl         w_ctl;
    logic [NUM_W-1:0]  w_num_x, w_num_y;
    logic [DEN_W-1:0]  w_den;
    logic              w_vx, w_vy, w_negy;
    logic [1:0]        w_tagx;
    logic [QUO_W:0]    w_qx, w_qy;
    logic signed [QUO_W+1:0] w_sx, w_sy;
    logic signed [QUO_W+2:0] w_x, w_y;
    logic              r_out_vld;
    logic [OUT_W-1:0]  r_x, r_y;
    logic              r_degen;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_A_X:    r_cfg.ax     <= i_cfg_data[CRD_W-1:0];
                REG_A_Y:    r_cfg.ay     <= i_cfg_data[CRD_W-1:0];
                REG_B_X:    r_cfg.bx     <= i_cfg_data[CRD_W-1:0];
                REG_B_Y:    r_cfg.by     <= i_cfg_data[CRD_W-1:0];
                REG_C_X:    r_cfg.cx     <= i_cfg_data[CRD_W-1:0];
                REG_C_Y:    r_cfg.cy     <= i_cfg_data[CRD_W-1:0];
                REG_IDS:    r_cfg.ids    <= i_cfg_data;
                REG_LOADED: r_cfg.loaded <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;

    tri2d_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_acc   (s_axis_tvalid && w_en),
        .i_cfg   (r_cfg),
        .i_ra    (s_axis_tdata[17:0]),
        .i_rb    (s_axis_tdata[35:18]),
        .i_rc    (s_axis_tdata[53:36]),
        .i_ida   (s_axis_tdata[61:54]),
        .i_idb   (s_axis_tdata[69:62]),
        .i_idc   (s_axis_tdata[77:70]),
        .i_count (s_axis_tdata[85:78]),
        .o_ctl   (w_ctl),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_den   (w_den)
    );

    tri2d_div #(.TAG_W(2)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_ctl.vld),
        .i_tag   ({w_ctl.degen, w_ctl.neg_x}),
        .i_num   (w_num_x),
        .i_den   (w_den),
        .o_vld   (w_vx),
        .o_tag   (w_tagx),
        .o_quo   (w_qx)
    );

    tri2d_div #(.TAG_W(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_ctl.vld),
        .i_tag   (w_ctl.neg_y),
        .i_num   (w_num_y),
        .i_den   (w_den),
        .o_vld   (w_vy),
        .o_tag   (w_negy),
        .o_quo   (w_qy)
    );

    assign w_sx = w_tagx[0] ? -$signed({1'b0, w_qx}) : $signed({1'b0, w_qx});
    assign w_sy = w_negy    ? -$signed({1'b0, w_qy}) : $signed({1'b0, w_qy});
    assign w_x  = (QUO_W+3)'(r_cfg.ax) + (QUO_W+3)'(w_sx) + (QUO_W+3)'(OFFSET_X_MM);
    assign w_y  = (QUO_W+3)'(r_cfg.ay) + (QUO_W+3)'(w_sy) + (QUO_W+3)'(OFFSET_Y_MM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_vx && w_vy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_degen <= w_tagx[1];
            if (w_tagx[1]) begin
                r_x <= '0;
                r_y <= '0;
            end else begin
                if (w_x > (QUO_W+3)'(524287)) begin
                    r_x <= OUT_W'(524287);
                end else if (w_x < -(QUO_W+3)'(524288)) begin
                    r_x <= OUT_W'(-524288);
                end else begin
                    r_x <= w_x[OUT_W-1:0];
                end
                if (w_y > (QUO_W+3)'(524287)) begin
                    r_y <= OUT_W'(524287);
                end else if (w_y < -(QUO_W+3)'(524288)) begin
                    r_y <= OUT_W'(-524288);
                end else begin
                    r_y <= w_y[OUT_W-1:0];
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_y, r_x};
    assign m_axis_tuser  = r_degen;

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero coordinates");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready out of step with output stall");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// File: sv/tri2d_geom.sv
// geometry pipeline: set checks, products and the two division operands
module tri2d_geom
    import tri2d_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_acc,
    input  t_cfg                    i_cfg,
    input  logic [RNG_W-1:0]        i_ra,
    input  logic [RNG_W-1:0]        i_rb,
    input  logic [RNG_W-1:0]        i_rc,
    input  logic [ID_W-1:0]         i_ida,
    input  logic [ID_W-1:0]         i_idb,
    input  logic [ID_W-1:0]         i_idc,
    input  logic [ID_W-1:0]         i_count,
    output t_geom_ctl               o_ctl,
    output logic [NUM_W-1:0]        o_num_x,
    output logic [NUM_W-1:0]        o_num_y,
    output logic [DEN_W-1:0]        o_den
);

    logic [7:0] r_vld;
    logic       n_ok;

    logic [RNG_W-1:0] r0_ra, r0_rb, r0_rc;
    logic signed [18:0] r1_ux, r1_uy, r1_vx, r1_vy;
    logic [35:0] r1_ra2, r1_rb2, r1_rc2;
    logic signed [18:0] r2_ux, r2_uy, r2_vx, r2_vy;
    logic signed [37:0] r2_m1, r2_m2, r2_ux2, r2_uy2, r2_vx2, r2_vy2;
    logic signed [36:0] r2_sa, r2_sb;
    logic signed [18:0] r3_ux, r3_uy, r3_vx, r3_vy;
    logic signed [38:0] r3_cross;
    logic signed [39:0] r3_p, r3_q;
    logic signed [58:0] r4_pvy, r4_quy, r4_qux, r4_pvx;
    logic signed [38:0] r4_cross;
    logic signed [59:0] r5_nx, r5_ny;
    logic signed [38:0] r5_cross;
    logic               r5_degen;
    logic signed [59:0] r6_sx, r6_sy;
    logic [37:0]        r6_dn;
    logic               r6_degen;
    logic               r7_degen, r7_negx, r7_negy;
    logic [NUM_W-1:0]   r7_nx, r7_ny;
    logic [DEN_W-1:0]   r7_den;
    logic [58:0]        n_magx, n_magy;

    assign n_ok = i_acc && i_cfg.loaded && (i_count >= ID_W'(MIN_RANGES))
                  && (i_ida == i_cfg.ids[7:0]) && (i_idb == i_cfg.ids[15:8])
                  && (i_idc == i_cfg.ids[23:16]);

    assign n_magx = r6_sx[59] ? 59'(-r6_sx) : r6_sx[58:0];
    assign n_magy = r6_sy[59] ? 59'(-r6_sy) : r6_sy[58:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:0], n_ok};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r0_ra <= i_ra;
            r0_rb <= i_rb;
            r0_rc <= i_rc;
            // anchor differences and squared ranges
            r1_ux  <= 19'(i_cfg.bx) - 19'(i_cfg.ax);
            r1_uy  <= 19'(i_cfg.by) - 19'(i_cfg.ay);
            r1_vx  <= 19'(i_cfg.cx) - 19'(i_cfg.ax);
            r1_vy  <= 19'(i_cfg.cy) - 19'(i_cfg.ay);
            r1_ra2 <= r0_ra * r0_ra;
            r1_rb2 <= r0_rb * r0_rb;
            r1_rc2 <= r0_rc * r0_rc;
            r2_ux  <= r1_ux;
            r2_uy  <= r1_uy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;
            r2_m1  <= r1_ux * r1_vy;
            r2_m2  <= r1_uy * r1_vx;
            r2_ux2 <= r1_ux * r1_ux;
            r2_uy2 <= r1_uy * r1_uy;
            r2_vx2 <= r1_vx * r1_vx;
            r2_vy2 <= r1_vy * r1_vy;
            r2_sa  <= $signed({1'b0, r1_ra2}) - $signed({1'b0, r1_rb2});
            r2_sb  <= $signed({1'b0, r1_ra2}) - $signed({1'b0, r1_rc2});
            r3_ux    <= r2_ux;
            r3_uy    <= r2_uy;
            r3_vx    <= r2_vx;
            r3_vy    <= r2_vy;
            r3_cross <= 39'(r2_m1) - 39'(r2_m2);
            r3_p     <= 40'(r2_sa) + 40'(r2_ux2) + 40'(r2_uy2);
            r3_q     <= 40'(r2_sb) + 40'(r2_vx2) + 40'(r2_vy2);
            r4_pvy   <= r3_p * r3_vy;
            r4_quy   <= r3_q * r3_uy;
            r4_qux   <= r3_q * r3_ux;
            r4_pvx   <= r3_p * r3_vx;
            r4_cross <= r3_cross;
            r5_nx    <= 60'(r4_pvy) - 60'(r4_quy);
            r5_ny    <= 60'(r4_qux) - 60'(r4_pvx);
            r5_cross <= r4_cross;
            r5_degen <= (r4_cross == '0);
            // make the denominator positive
            r6_sx    <= r5_cross[38] ? -r5_nx : r5_nx;
            r6_sy    <= r5_cross[38] ? -r5_ny : r5_ny;
            r6_dn    <= r5_cross[38] ? 38'(-r5_cross) : r5_cross[37:0];
            r6_degen <= r5_degen;
            // rounding: (2*mag + den2) / (2*den2), den2 = 2*cross
            r7_negx  <= r6_sx[59];
            r7_negy  <= r6_sy[59];
            r7_degen <= r6_degen;
            r7_den   <= {r6_dn, 2'b00};
            r7_nx    <= NUM_W'({n_magx, 1'b0}) + NUM_W'({r6_dn, 1'b0});
            r7_ny    <= NUM_W'({n_magy, 1'b0}) + NUM_W'({r6_dn, 1'b0});
        end
    end

    assign o_ctl.vld   = r_vld[7];
    assign o_ctl.degen = r7_degen;
    assign o_ctl.neg_x = r7_negx;
    assign o_ctl.neg_y = r7_negy;
    assign o_num_x     = r7_nx;
    assign o_num_y     = r7_ny;
    assign o_den       = r7_den;

endmodule

// File: sv/tri2d_div.sv
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module tri2d_div
    import tri2d_pkg::*;
#(
    parameter int TAG_W = 1
)
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic [TAG_W-1:0]   i_tag,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    output logic               o_vld,
    output logic [TAG_W-1:0]   o_tag,
    output logic [QUO_W:0]     o_quo
);

    localparam int TW = NUM_W + QUO_W;

    logic [QUO_W:0]     r_vld;
    logic [TAG_W-1:0]   r_tag [QUO_W+1];
    logic [NUM_W-1:0]   r_rem [QUO_W+1];
    logic [DEN_W-1:0]   r_den [QUO_W+1];
    logic [QUO_W-1:0]   r_q   [QUO_W+1];
    logic               r_ovf [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_ovf[0] <= (TW'(i_num) >= (TW'(i_den) << QUO_W));
        end
    end

    for (genvar gi = 0; gi < QUO_W; gi++) begin : g_stage
        localparam int SH = QUO_W - 1 - gi;
        logic [TW-1:0] w_trial;
        logic          w_ge;

        assign w_trial = TW'(r_den[gi]) << SH;
        assign w_ge    = (TW'(r_rem[gi]) >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[gi+1] <= r_vld[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[gi+1] <= r_tag[gi];
                r_den[gi+1] <= r_den[gi];
                r_ovf[gi+1] <= r_ovf[gi];
                r_rem[gi+1] <= w_ge ? (r_rem[gi] - w_trial[NUM_W-1:0]) : r_rem[gi];
                r_q[gi+1]   <= {r_q[gi][QUO_W-2:0], w_ge};
            end
        end
    end

    assign o_vld = r_vld[QUO_W];
    assign o_tag = r_tag[QUO_W];
    assign o_quo = r_ovf[QUO_W] ? ((QUO_W+1)'(1) << QUO_W) : {1'b0, r_q[QUO_W]};

endmodule
